>>> rtl/bfha_pkg.sv
// Shared types, codes and constants of the best-fit hole allocator.
`default_nettype none
package bfha_pkg;

    localparam int START_W  = 10;
    localparam int LEN_W    = 11;
    localparam int SLACK_W  = 4;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_NOFIT = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam logic [SLACK_W-1:0] SLACK_RESET = 4'd2;

    // Byte address of the split_slack register.
    localparam logic [0:0] ADDR_SPLIT_SLACK = 1'b0;

    typedef struct packed {
        logic               action;
        logic [START_W-1:0] block_start;
        logic [LEN_W-1:0]   block_length;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [START_W-1:0] grant_start;
        logic [LEN_W-1:0]   grant_length;
    } t_rsp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE
    } t_state;

    typedef struct packed {
        logic clear;
        logic eval;
        logic is_free;
    } t_scan_ctl;

    typedef struct packed {
        logic wr_en;
        logic set_used;
        logic clr_used;
    } t_tbl_ctl;

endpackage
`default_nettype wire

>>> rtl/bfha_table.sv
// Hole table: base/size memory with one read and one write port, plus used flags.
`default_nettype none
module bfha_table #(
    parameter int MAX_HOLES  = 16,
    parameter int POOL_WORDS = 1024,
    parameter int IDX_W      = 4,
    parameter int BASE_W     = 10,
    parameter int SIZE_W     = 11
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_rd_en,
    input  wire logic [IDX_W-1:0]     i_rd_idx,
    output logic                      o_rd_used,
    output logic [BASE_W-1:0]         o_rd_base,
    output logic [SIZE_W-1:0]         o_rd_size,
    input  wire bfha_pkg::t_tbl_ctl   i_ctl,
    input  wire logic [IDX_W-1:0]     i_wr_idx,
    input  wire logic [BASE_W-1:0]    i_wr_base,
    input  wire logic [SIZE_W-1:0]    i_wr_size,
    input  wire logic [IDX_W-1:0]     i_clr_idx
);
    import bfha_pkg::*;

    logic [BASE_W+SIZE_W-1:0] r_hole_mem [MAX_HOLES];
    logic [BASE_W+SIZE_W-1:0] r_rd_data;
    logic [IDX_W-1:0]         r_rd_idx;
    logic [MAX_HOLES-1:0]     r_used;
    logic                     r_init0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_hole_mem[i_wr_idx] <= {i_wr_base, i_wr_size};
        end
        if (i_rd_en) begin
            r_rd_data <= r_hole_mem[i_rd_idx];
            r_rd_idx  <= i_rd_idx;
        end
    end

    // Entry zero holds the whole pool after reset until it is first written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= MAX_HOLES'(1);
            r_init0 <= 1'b1;
        end else begin
            if (i_ctl.clr_used) begin
                r_used[i_clr_idx] <= 1'b0;
            end
            if (i_ctl.set_used) begin
                r_used[i_wr_idx] <= 1'b1;
            end
            if (i_ctl.wr_en && (i_wr_idx == '0)) begin
                r_init0 <= 1'b0;
            end
        end
    end

    always_comb begin
        o_rd_used = r_used[r_rd_idx];
        if (r_init0 && (r_rd_idx == '0)) begin
            o_rd_base = '0;
            o_rd_size = SIZE_W'(POOL_WORDS);
        end else begin
            o_rd_base = r_rd_data[BASE_W+SIZE_W-1:SIZE_W];
            o_rd_size = r_rd_data[SIZE_W-1:0];
        end
    end

endmodule
`default_nettype wire

>>> rtl/bfha_scan.sv
// Shared compare unit that folds one table entry per cycle into the running picks.
`default_nettype none
module bfha_scan #(
    parameter int IDX_W = 4,
    parameter int AW    = 11
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire bfha_pkg::t_scan_ctl  i_ctl,
    input  wire logic [AW-1:0]        i_len,
    input  wire logic [AW-1:0]        i_start,
    input  wire logic [AW-1:0]        i_end,
    input  wire logic [IDX_W-1:0]     i_idx,
    input  wire logic                 i_used,
    input  wire logic [AW-1:0]        i_base,
    input  wire logic [AW-1:0]        i_size,
    output logic                      o_best_found,
    output logic [IDX_W-1:0]          o_best_idx,
    output logic [AW-1:0]             o_best_base,
    output logic [AW-1:0]             o_best_size,
    output logic                      o_below_found,
    output logic [IDX_W-1:0]          o_below_idx,
    output logic [AW-1:0]             o_below_base,
    output logic                      o_above_found,
    output logic [IDX_W-1:0]          o_above_idx,
    output logic [AW-1:0]             o_above_size,
    output logic                      o_slot_found,
    output logic [IDX_W-1:0]          o_slot_idx
);
    import bfha_pkg::*;

    logic             r_best_found, r_below_found, r_above_found, r_slot_found;
    logic [IDX_W-1:0] r_best_idx, r_below_idx, r_above_idx, r_slot_idx;
    logic [AW-1:0]    r_best_base, r_best_size, r_below_base, r_above_size;

    logic [AW:0] w_top;
    logic        w_fit, w_better, w_is_below, w_is_above;

    always_comb begin
        w_top      = {1'b0, i_base} + {1'b0, i_size};
        w_fit      = i_used && (i_size >= i_len);
        w_better   = !r_best_found || (i_size < r_best_size) ||
                     ((i_size == r_best_size) && (i_base < r_best_base));
        w_is_below = i_used && (w_top == {1'b0, i_start});
        w_is_above = i_used && (i_base == i_end);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_best_found  <= 1'b0;
            r_below_found <= 1'b0;
            r_above_found <= 1'b0;
            r_slot_found  <= 1'b0;
        end else if (i_ctl.eval) begin
            if (!i_ctl.is_free) begin
                if (w_fit && w_better) begin
                    r_best_found <= 1'b1;
                end
            end else begin
                if (!i_used && !r_slot_found) begin
                    r_slot_found <= 1'b1;
                end
                if (w_is_below && !r_below_found) begin
                    r_below_found <= 1'b1;
                end
                if (w_is_above && !r_above_found) begin
                    r_above_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.eval) begin
            if (!i_ctl.is_free) begin
                if (w_fit && w_better) begin
                    r_best_idx  <= i_idx;
                    r_best_base <= i_base;
                    r_best_size <= i_size;
                end
            end else begin
                if (!i_used && !r_slot_found) begin
                    r_slot_idx <= i_idx;
                end
                if (w_is_below && !r_below_found) begin
                    r_below_idx  <= i_idx;
                    r_below_base <= i_base;
                end
                if (w_is_above && !r_above_found) begin
                    r_above_idx  <= i_idx;
                    r_above_size <= i_size;
                end
            end
        end
    end

    assign o_best_found  = r_best_found;
    assign o_best_idx    = r_best_idx;
    assign o_best_base   = r_best_base;
    assign o_best_size   = r_best_size;
    assign o_below_found = r_below_found;
    assign o_below_idx   = r_below_idx;
    assign o_below_base  = r_below_base;
    assign o_above_found = r_above_found;
    assign o_above_idx   = r_above_idx;
    assign o_above_size  = r_above_size;
    assign o_slot_found  = r_slot_found;
    assign o_slot_idx    = r_slot_idx;

endmodule
`default_nettype wire

>>> rtl/best_fit_hole_allocator.sv
// Top level of the best-fit hole allocator: sequencer, register port and result register.
`default_nettype none
// Best-fit hole allocator. Each transaction on the request channel is an allocate
// or a free and produces exactly one response. The block walks the hole table one
// entry per cycle through the single read port of the table memory, so a request
// passes through the accept in the idle state, a scan of every entry with the
// registered read, and the update state; the response is registered at the update
// and the block returns to idle with it, so the next request can be taken while the
// response is presented. A response that has not been consumed holds the following
// request in its update cycle until the response is taken. Requests are not accepted
// while one is in progress. No clearing pass is needed after reset. split_slack sits
// at byte address 0 of the register port and may only be written while the block is idle.
module best_fit_hole_allocator #(
    parameter int POOL_WORDS = 1024,
    parameter int MAX_HOLES  = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire bfha_pkg::t_req   i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output bfha_pkg::t_rsp        o_out_data,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [0:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import bfha_pkg::*;

    localparam int BASE_W = $clog2(POOL_WORDS);
    localparam int SIZE_W = $clog2(POOL_WORDS + 1);
    localparam int AW     = (SIZE_W > LEN_W) ? SIZE_W : LEN_W;
    localparam int IDX_W  = $clog2(MAX_HOLES);
    localparam int CNT_W  = $clog2(MAX_HOLES + 1);
    localparam logic [AW-1:0]    POOL_AW  = AW'(POOL_WORDS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_HOLES);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_eval;
    logic               r_action;
    logic               r_nop;
    logic [AW-1:0]      r_len, r_start, r_end;
    logic [SLACK_W-1:0] r_slack;
    logic               r_out_valid;
    t_rsp               r_out;

    logic               w_in_fire, w_rd_en, w_commit;
    t_scan_ctl          w_scan_ctl;
    t_tbl_ctl           w_tbl_ctl;
    logic [AW-1:0]      w_req_start, w_req_len, w_req_end;
    logic [AW:0]        w_req_sum;

    logic               w_rd_used;
    logic [BASE_W-1:0]  w_rd_base;
    logic [SIZE_W-1:0]  w_rd_size;

    logic               w_best_found, w_below_found, w_above_found, w_slot_found;
    logic [IDX_W-1:0]   w_best_idx, w_below_idx, w_above_idx, w_slot_idx;
    logic [AW-1:0]      w_best_base, w_best_size, w_below_base, w_above_size;

    logic [AW-1:0]      w_leftover, w_merge_low, w_merge_size;
    logic [AW:0]        w_merge_top, w_merge_diff;
    logic               w_absorb, w_nofit;
    logic [IDX_W-1:0]   w_wr_idx;
    logic [AW-1:0]      w_wr_base, w_wr_size, w_grant_start, w_grant_len;
    logic [1:0]         w_status;
    logic               w_tbl_wr, w_tbl_set, w_tbl_clr;
    logic [IDX_W-1:0]   w_clr_idx;

    // Register port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slack <= SLACK_RESET;
        end else if (psel && penable && pwrite && (paddr == ADDR_SPLIT_SLACK)) begin
            r_slack <= pwdata[SLACK_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_SPLIT_SLACK) ? {{(32 - SLACK_W){1'b0}}, r_slack} : '0;

    // Request capture; a free running past the pool end is clipped here.
    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_fire  = i_in_valid && o_in_ready;

    always_comb begin
        w_req_start = AW'(i_in_data.block_start);
        w_req_len   = AW'(i_in_data.block_length);
        w_req_sum   = {1'b0, w_req_start} + {1'b0, w_req_len};
        w_req_end   = (w_req_sum > {1'b0, POOL_AW}) ? POOL_AW : w_req_sum[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_action <= i_in_data.action;
            r_len    <= w_req_len;
            r_start  <= w_req_start;
            r_end    <= w_req_end;
            r_nop    <= (i_in_data.action == ACT_FREE) &&
                        ((w_req_len == '0) || (w_req_start >= POOL_AW));
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_eval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_eval  <= w_rd_en;
            if (w_in_fire) begin
                r_cnt <= '0;
            end else if (w_rd_en) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        w_rd_en            = 1'b0;
        w_commit           = 1'b0;
        w_scan_ctl.clear   = w_in_fire;
        w_scan_ctl.eval    = 1'b0;
        w_scan_ctl.is_free = r_action;
        case (r_state)
            S_SCAN: begin
                w_rd_en         = (r_cnt < CNT_LAST);
                w_scan_ctl.eval = r_eval;
            end
            S_WRITE: begin
                w_commit = !r_out_valid || i_out_ready;
            end
            default: begin
                w_rd_en = 1'b0;
            end
        endcase
    end

    bfha_table #(
        .MAX_HOLES  (MAX_HOLES),
        .POOL_WORDS (POOL_WORDS),
        .IDX_W      (IDX_W),
        .BASE_W     (BASE_W),
        .SIZE_W     (SIZE_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_rd_en),
        .i_rd_idx  (r_cnt[IDX_W-1:0]),
        .o_rd_used (w_rd_used),
        .o_rd_base (w_rd_base),
        .o_rd_size (w_rd_size),
        .i_ctl     (w_tbl_ctl),
        .i_wr_idx  (w_wr_idx),
        .i_wr_base (w_wr_base[BASE_W-1:0]),
        .i_wr_size (w_wr_size[SIZE_W-1:0]),
        .i_clr_idx (w_clr_idx)
    );

    bfha_scan #(
        .IDX_W (IDX_W),
        .AW    (AW)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_scan_ctl),
        .i_len         (r_len),
        .i_start       (r_start),
        .i_end         (r_end),
        .i_idx         (IDX_W'(r_cnt - CNT_W'(1))),
        .i_used        (w_rd_used),
        .i_base        (AW'(w_rd_base)),
        .i_size        (AW'(w_rd_size)),
        .o_best_found  (w_best_found),
        .o_best_idx    (w_best_idx),
        .o_best_base   (w_best_base),
        .o_best_size   (w_best_size),
        .o_below_found (w_below_found),
        .o_below_idx   (w_below_idx),
        .o_below_base  (w_below_base),
        .o_above_found (w_above_found),
        .o_above_idx   (w_above_idx),
        .o_above_size  (w_above_size),
        .o_slot_found  (w_slot_found),
        .o_slot_idx    (w_slot_idx)
    );

    // Table update and response. A free that is neither a no-op nor refused writes one entry
    // from the lower neighbor (or freed start) up to the upper neighbor's end (or freed end).
    always_comb begin
        w_leftover   = w_best_size - r_len;
        w_absorb     = (w_leftover <= AW'(r_slack));
        w_nofit      = (r_len == '0) || !w_best_found;
        w_merge_top  = w_above_found ? ({1'b0, r_end} + {1'b0, w_above_size}) : {1'b0, r_end};
        w_merge_low  = w_below_found ? w_below_base : r_start;
        w_merge_diff = w_merge_top - {1'b0, w_merge_low};
        w_merge_size = (w_merge_diff > {1'b0, POOL_AW}) ? POOL_AW : w_merge_diff[AW-1:0];

        w_tbl_wr      = 1'b0;
        w_tbl_set     = 1'b0;
        w_tbl_clr     = 1'b0;
        w_wr_idx      = w_best_idx;
        w_clr_idx     = w_best_idx;
        w_wr_base     = w_best_base + r_len;
        w_wr_size     = w_leftover;
        w_grant_start = '0;
        w_grant_len   = '0;
        w_status      = STATUS_DONE;

        if (r_action == ACT_ALLOC) begin
            if (w_nofit) begin
                w_status = STATUS_NOFIT;
            end else begin
                w_grant_start = w_best_base;
                if (w_absorb) begin
                    w_tbl_clr   = 1'b1;
                    w_grant_len = w_best_size;
                end else begin
                    w_tbl_wr    = 1'b1;
                    w_grant_len = r_len;
                end
            end
        end else if (!r_nop) begin
            w_wr_base = w_merge_low;
            w_wr_size = w_merge_size;
            w_clr_idx = w_above_idx;
            if (w_below_found) begin
                w_wr_idx  = w_below_idx;
                w_tbl_wr  = 1'b1;
                w_tbl_clr = w_above_found;
            end else if (w_above_found) begin
                w_wr_idx = w_above_idx;
                w_tbl_wr = 1'b1;
            end else if (w_slot_found) begin
                w_wr_idx  = w_slot_idx;
                w_tbl_wr  = 1'b1;
                w_tbl_set = 1'b1;
            end else begin
                w_status = STATUS_FULL;
            end
        end

        w_tbl_ctl.wr_en    = w_commit && w_tbl_wr;
        w_tbl_ctl.set_used = w_commit && w_tbl_set;
        w_tbl_ctl.clr_used = w_commit && w_tbl_clr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out.status       <= w_status;
            r_out.grant_start  <= w_grant_start[START_W-1:0];
            r_out.grant_length <= w_grant_len[LEN_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != STATUS_DONE)) |->
        ((o_out_data.grant_start == '0) && (o_out_data.grant_length == '0)))
        else $error("failed transaction carries a nonzero grant");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_LAST)
        else $error("scan counter ran past the table");

    a_commit_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> (o_out_valid && (r_state == S_IDLE)))
        else $error("update did not present a response");

    a_write_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tbl_ctl.wr_en || w_tbl_ctl.clr_used) |-> (r_state == S_WRITE))
        else $error("table changed outside the update cycle");

endmodule
`default_nettype wire

>>> tb/best_fit_hole_allocator_tb.sv
// Self-checking testbench for the best-fit hole allocator: directed and random traffic.
module best_fit_hole_allocator_tb;
    import bfha_pkg::*;

    localparam int POOL_WORDS  = 1024;
    localparam int MAX_HOLES   = 16;
    localparam int LATENCY     = MAX_HOLES + 3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_PRINTS  = 30;

    typedef struct {
        int base;
        int size;
    } t_span;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_req        i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_rsp        o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predicted copy of the hole table and of the slack register.
    logic [START_W-1:0] hole_base [MAX_HOLES];
    logic [LEN_W-1:0]   hole_size [MAX_HOLES];
    logic               hole_used [MAX_HOLES];
    logic [SLACK_W-1:0] slack_q;

    t_rsp  expected_rsp[$];
    // Blocks the traffic currently holds, so that most frees give back real grants.
    t_span owned[$];

    int mismatches;
    int cycles;
    int n_alloc;
    int n_free;
    int n_checked;
    int n_grant;
    int n_nofit;
    int n_full;
    bit idle_on;
    int rx_hold;

    best_fit_hole_allocator #(
        .POOL_WORDS(POOL_WORDS),
        .MAX_HOLES (MAX_HOLES)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles, %0d responses outstanding",
                     cycles, expected_rsp.size());
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS) begin
            $display("cycle %0d: %s", cycles, msg);
        end
    endtask

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int alloc_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return $urandom_range(0, 2047);
        if (r < 75) return $urandom_range(1, 32);
        if (r < 93) return $urandom_range(1, 200);
        return $urandom_range(201, POOL_WORDS);
    endfunction

    function automatic logic [LEN_W-1:0] sat_pool(input int words);
        return (words > POOL_WORDS) ? LEN_W'(POOL_WORDS) : LEN_W'(words);
    endfunction

    // Works out the response to one request and applies it to the predicted table.
    function automatic t_rsp predict_response(input t_req req);
        t_rsp rsp;
        int   len;
        int   start;
        int   stop;
        int   best;
        int   below;
        int   above;
        int   slot;
        rsp = '0;
        rsp.status = STATUS_DONE;
        len = int'(req.block_length);
        start = int'(req.block_start);
        if (req.action == ACT_ALLOC) begin
            best = -1;
            if (len != 0) begin
                for (int i = 0; i < MAX_HOLES; i++) begin
                    if (hole_used[i] && int'(hole_size[i]) >= len) begin
                        if (best < 0 || hole_size[i] < hole_size[best] ||
                            (hole_size[i] == hole_size[best] &&
                             hole_base[i] < hole_base[best])) begin
                            best = i;
                        end
                    end
                end
            end
            if (best < 0) begin
                rsp.status = STATUS_NOFIT;
            end else begin
                rsp.grant_start = hole_base[best];
                if (int'(hole_size[best]) - len <= int'(slack_q)) begin
                    rsp.grant_length = hole_size[best];
                    hole_used[best] = 1'b0;
                    hole_base[best] = '0;
                    hole_size[best] = '0;
                end else begin
                    rsp.grant_length = LEN_W'(len);
                    hole_base[best] = START_W'(int'(hole_base[best]) + len);
                    hole_size[best] = LEN_W'(int'(hole_size[best]) - len);
                end
            end
        end else if (len != 0 && start < POOL_WORDS) begin
            if (len > POOL_WORDS - start) len = POOL_WORDS - start;
            stop = start + len;
            below = -1;
            above = -1;
            slot = -1;
            for (int i = 0; i < MAX_HOLES; i++) begin
                if (!hole_used[i]) begin
                    if (slot < 0) slot = i;
                end else begin
                    if (below < 0 && int'(hole_base[i]) + int'(hole_size[i]) == start) below = i;
                    if (above < 0 && int'(hole_base[i]) == stop) above = i;
                end
            end
            if (below >= 0 && above >= 0) begin
                hole_size[below] = sat_pool(int'(hole_size[below]) + len +
                                            int'(hole_size[above]));
                hole_used[above] = 1'b0;
                hole_base[above] = '0;
                hole_size[above] = '0;
            end else if (below >= 0) begin
                hole_size[below] = sat_pool(int'(hole_size[below]) + len);
            end else if (above >= 0) begin
                hole_base[above] = START_W'(start);
                hole_size[above] = sat_pool(int'(hole_size[above]) + len);
            end else if (slot < 0) begin
                rsp.status = STATUS_FULL;
            end else begin
                hole_used[slot] = 1'b1;
                hole_base[slot] = START_W'(start);
                hole_size[slot] = LEN_W'(len);
            end
        end
        return rsp;
    endfunction

    // Sends one request and records its expected response once the request is accepted.
    task automatic send_request(input logic act, input int start, input int len);
        t_req  req;
        t_rsp  rsp;
        t_span held;
        int    gap;
        req.action = act;
        req.block_start = START_W'(start);
        req.block_length = LEN_W'(len);
        gap = idle_on ? idle_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data = req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        rsp = predict_response(req);
        expected_rsp.insert(expected_rsp.size(), rsp);
        if (act == ACT_ALLOC) begin
            n_alloc++;
            if (rsp.status == STATUS_DONE) begin
                held.base = int'(rsp.grant_start);
                held.size = int'(rsp.grant_length);
                owned.insert(owned.size(), held);
            end
        end else begin
            n_free++;
        end
    endtask

    task automatic give_back(input int start, input int len);
        int k;
        k = -1;
        for (int i = 0; i < owned.size(); i++) begin
            if (k < 0 && owned[i].base == start) k = i;
        end
        if (k >= 0) owned.delete(k);
        send_request(ACT_FREE, start, len);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_rsp.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Writes split_slack and reads it back.
    task automatic write_slack(input int value);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = ADDR_SPLIT_SLACK;
        pwdata = 32'(value);
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        slack_q = SLACK_W'(value);
        @(negedge i_clk);
        pwrite = 1'b0;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {{(32 - SLACK_W){1'b0}}, slack_q}) begin
            report_mismatch($sformatf("split_slack reads %0h, expected %0h", prdata, slack_q));
        end
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    always @(posedge i_clk) begin : check_responses
        t_rsp exp_rsp;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_rsp.size() == 0) begin
                report_mismatch($sformatf("response %h with no request pending", o_out_data));
            end else begin
                exp_rsp = expected_rsp.pop_front();
                n_checked++;
                if (o_out_data.status !== exp_rsp.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_out_data.status, exp_rsp.status));
                end
                if (o_out_data.grant_start !== exp_rsp.grant_start) begin
                    report_mismatch($sformatf("grant_start %0d, expected %0d",
                                              o_out_data.grant_start, exp_rsp.grant_start));
                end
                if (o_out_data.grant_length !== exp_rsp.grant_length) begin
                    report_mismatch($sformatf("grant_length %0d, expected %0d",
                                              o_out_data.grant_length, exp_rsp.grant_length));
                end
                if (exp_rsp.status == STATUS_NOFIT) begin
                    n_nofit++;
                end else if (exp_rsp.status == STATUS_FULL) begin
                    n_full++;
                end else if (exp_rsp.grant_length != 0) begin
                    n_grant++;
                end
            end
        end
    end

    // The receiver holds ready low for random stretches while idling is enabled.
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
        end else if (idle_on && $urandom_range(0, 99) < 25) begin
            i_out_ready = 1'b0;
            rx_hold = idle_gap();
        end else begin
            i_out_ready = 1'b1;
        end
    end

    task automatic test_idle_cases();
        send_request(ACT_ALLOC, 1023, 0);
        send_request(ACT_FREE, 1023, 0);
        send_request(ACT_ALLOC, 0, 2047);
    endtask

    task automatic test_pool_extremes();
        // A leftover of two words falls within the reset slack, so the whole pool is granted.
        send_request(ACT_ALLOC, 0, 1022);
        // This one runs past the pool end and is clipped to the last word.
        give_back(1023, 2047);
        give_back(0, 1023);
    endtask

    task automatic test_best_fit_ties();
        wait_drained();
        write_slack(0);
        send_request(ACT_ALLOC, 0, 50);
        send_request(ACT_ALLOC, 0, 10);
        send_request(ACT_ALLOC, 0, 50);
        send_request(ACT_ALLOC, 0, 10);
        give_back(60, 50);
        give_back(0, 50);
        // Two equal holes: the lower start wins although it sits in the higher entry.
        send_request(ACT_ALLOC, 1023, 50);
        // The small hole beats the large one and is split.
        send_request(ACT_ALLOC, 0, 40);
    endtask

    task automatic test_table_full();
        t_span blk;
        t_span piece;
        send_request(ACT_ALLOC, 0, 64);
        blk = owned.pop_back();
        // Two entries are in use, so fourteen isolated words fill the table and the
        // fifteenth is refused.
        for (int k = 0; k < 15; k++) begin
            send_request(ACT_FREE, blk.base + 2 * k, 1);
        end
        for (int k = 0; k < 14; k++) begin
            piece.base = blk.base + 2 * k + 1;
            piece.size = 1;
            owned.insert(owned.size(), piece);
        end
        piece.base = blk.base + 28;
        piece.size = 36;
        owned.insert(owned.size(), piece);
    endtask

    task automatic test_random_traffic(input int count, input int slack, input bit idle);
        int    r;
        int    k;
        int    cut;
        t_span s;
        wait_drained();
        write_slack(slack);
        idle_on = idle;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (owned.size() != 0 && (r < 40 || owned.size() > 48)) begin
                k = $urandom_range(0, owned.size() - 1);
                s = owned[k];
                if ($urandom_range(0, 9) == 0 && s.size > 1) begin
                    // Return only the low part of a held block.
                    cut = $urandom_range(1, s.size - 1);
                    owned[k].base = s.base + cut;
                    owned[k].size = s.size - cut;
                    send_request(ACT_FREE, s.base, cut);
                end else begin
                    owned.delete(k);
                    send_request(ACT_FREE, s.base, s.size);
                end
            end else if (r < 95) begin
                send_request(ACT_ALLOC, $urandom_range(0, 1023), alloc_len());
            end else begin
                send_request(ACT_FREE, $urandom_range(0, 1023), $urandom_range(0, 2047));
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b1;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = ADDR_SPLIT_SLACK;
        pwdata = '0;
        mismatches = 0;
        cycles = 0;
        n_alloc = 0;
        n_free = 0;
        n_checked = 0;
        n_grant = 0;
        n_nofit = 0;
        n_full = 0;
        rx_hold = 0;
        idle_on = 1'b1;
        for (int i = 0; i < MAX_HOLES; i++) begin
            hole_base[i] = '0;
            hole_size[i] = '0;
            hole_used[i] = 1'b0;
        end
        hole_size[0] = LEN_W'(POOL_WORDS);
        hole_used[0] = 1'b1;
        slack_q = SLACK_RESET;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_idle_cases();
        test_pool_extremes();
        test_best_fit_ties();
        test_table_full();
        test_random_traffic(330, 15, 1'b1);
        test_random_traffic(330, 0, 1'b0);
        test_random_traffic(330, $urandom_range(0, 15), 1'b1);
        test_random_traffic(330, 2, 1'b1);
        test_random_traffic(330, 9, 1'b0);
        test_random_traffic(330, $urandom_range(0, 15), 1'b1);
        wait_drained();

        $display("Sent %0d allocates and %0d frees under several slack settings;",
                 n_alloc, n_free);
        $display("%0d responses checked: %0d grants, %0d no-fit, %0d table-full, %0d mismatches.",
                 n_checked, n_grant, n_nofit, n_full, mismatches);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
